// ===== sv/cpu_opcode_decoder_macros.svh =====
// Assertion macros for the opcode decoder checker.
// Clocked on clk_i and disabled while rst_ni is low; no other dependencies.
`ifndef CPU_OPCODE_DECODER_MACROS_SVH
`define CPU_OPCODE_DECODER_MACROS_SVH

// Same-cycle implication on the rising edge of clk_i.
`define COD_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cpu_opcode_decoder: assertion failed");

// Delayed implication on the rising edge of clk_i.
`define COD_ASSERT_LAT2(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##2 (cons)) \
    else $error("cpu_opcode_decoder: latency assertion failed");

`endif

// ===== sv/cod_pkg.sv =====
// Shared types and constants for the opcode decoder.
// Used by cod_decode, cpu_opcode_decoder and cod_checker; no dependencies.
`default_nettype none

package cod_pkg;

  // One input transfer: the opcode and the byte that follows it.
  typedef struct packed {
    logic [7:0] opcode;
    logic [7:0] next_byte;
  } cod_in_t;

  // One decoded record.
  typedef struct packed {
    logic       valid_res;
    logic [5:0] kind;
    logic [1:0] length;
    logic [3:0] target;
    logic [7:0] immediate;
    logic [2:0] bit_index;
    logic       prefixed;
  } cod_out_t;

  // Special opcodes.
  localparam logic [7:0] OP_PREFIX  = 8'hCB;
  localparam logic [7:0] OP_RLCA    = 8'h07;
  localparam logic [7:0] OP_RLA     = 8'h17;
  localparam logic [7:0] OP_SCF     = 8'h37;
  localparam logic [7:0] OP_RRCA    = 8'h0F;
  localparam logic [7:0] OP_RRA     = 8'h1F;
  localparam logic [7:0] OP_CPL     = 8'h2F;
  localparam logic [7:0] OP_CCF     = 8'h3F;
  localparam logic [7:0] OP_JR_NZ   = 8'h20;
  localparam logic [7:0] OP_JR_NC   = 8'h30;
  localparam logic [7:0] OP_JR      = 8'h18;
  localparam logic [7:0] OP_JR_Z    = 8'h28;
  localparam logic [7:0] OP_JR_C    = 8'h38;
  localparam logic [7:0] OP_JP_NZ   = 8'hC2;
  localparam logic [7:0] OP_JP_NC   = 8'hD2;
  localparam logic [7:0] OP_JP      = 8'hC3;
  localparam logic [7:0] OP_JP_Z    = 8'hCA;
  localparam logic [7:0] OP_JP_C    = 8'hDA;
  localparam logic [7:0] OP_JP_HL   = 8'hE9;

  // Low-nibble codes in the first quarter of the opcode map.
  localparam logic [3:0] LO_INC16   = 4'h3;
  localparam logic [3:0] LO_ADDHL   = 4'h9;
  localparam logic [3:0] LO_DEC16   = 4'hB;
  localparam logic [3:0] LO_INC_A   = 4'h4;
  localparam logic [3:0] LO_INC_B   = 4'hC;
  localparam logic [3:0] LO_DEC_A   = 4'h5;
  localparam logic [3:0] LO_DEC_B   = 4'hD;
  localparam logic [2:0] COL_IMM    = 3'd6;

  // Instruction kinds.
  localparam logic [5:0] K_INCDUP   = 6'd0;
  localparam logic [5:0] K_JRNZERO  = 6'd1;
  localparam logic [5:0] K_JRNCARRY = 6'd2;
  localparam logic [5:0] K_INC      = 6'd3;
  localparam logic [5:0] K_DEC      = 6'd4;
  localparam logic [5:0] K_RLCA     = 6'd5;
  localparam logic [5:0] K_RLA      = 6'd6;
  localparam logic [5:0] K_SCF      = 6'd7;
  localparam logic [5:0] K_JRALWAYS = 6'd8;
  localparam logic [5:0] K_JRZERO   = 6'd9;
  localparam logic [5:0] K_JRCARRY  = 6'd10;
  localparam logic [5:0] K_ADDHL    = 6'd11;
  localparam logic [5:0] K_DECDUP   = 6'd12;
  localparam logic [5:0] K_RRCA     = 6'd13;
  localparam logic [5:0] K_RRA      = 6'd14;
  localparam logic [5:0] K_CPL      = 6'd15;
  localparam logic [5:0] K_CCF      = 6'd16;
  localparam logic [5:0] K_ALU_BASE = 6'd17;
  localparam logic [5:0] K_JPNZERO  = 6'd25;
  localparam logic [5:0] K_JPNCARRY = 6'd26;
  localparam logic [5:0] K_JPALWAYS = 6'd27;
  localparam logic [5:0] K_JPZERO   = 6'd28;
  localparam logic [5:0] K_JPCARRY  = 6'd29;
  localparam logic [5:0] K_CB_BASE  = 6'd30;
  localparam logic [5:0] K_BIT      = 6'd38;

  // Register targets.
  localparam logic [3:0] T_BC   = 4'd8;
  localparam logic [3:0] T_DE   = 4'd9;
  localparam logic [3:0] T_HL   = 4'd6;
  localparam logic [3:0] T_SP   = 4'd10;
  localparam logic [3:0] T_IMM  = 4'd11;
  localparam logic [3:0] T_NONE = 4'd12;

  // Lengths in bytes.
  localparam logic [1:0] LEN_1 = 2'd1;
  localparam logic [1:0] LEN_2 = 2'd2;
  localparam logic [1:0] LEN_3 = 2'd3;

  // Register-pair target selected by opcode bits 5:4.
  function automatic logic [3:0] pair_target(input logic [1:0] pr);
    logic [3:0] t;
    case (pr)
      2'd0:    t = T_BC;
      2'd1:    t = T_DE;
      2'd2:    t = T_HL;
      default: t = T_SP;
    endcase
    return t;
  endfunction

endpackage

`default_nettype wire

// ===== sv/cpu_opcode_decoder.sv =====
// Channel   Handshake            Payload
// command   start_i, busy_o      cmd_i  (cod_in_t: opcode, next_byte)
// result    done_o (strobe)      res_o  (cod_out_t: decoded record)
//
// A command is taken on every edge with start_i high; busy_o stays low.
// Each transfer yields one result via input register, decode and result register.
// Sustained rate is one command per cycle, set by the single decode pass between registers.
// The result is shown for one cycle only; the receiver cannot stall it.
// Reset clears both strobe registers; payload registers are not reset.
//
// Top level of the opcode decoder; depends on cod_pkg and cod_decode.
`default_nettype none

module cpu_opcode_decoder (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  cod_pkg::cod_in_t  cmd_i,
  output logic              done_o,
  output cod_pkg::cod_out_t res_o
);
  import cod_pkg::*;

  logic     in_valid_q;
  logic     in_valid_d;
  cod_in_t  in_q;
  logic     out_valid_q;
  cod_out_t out_d;
  cod_out_t out_q;

  // The pipeline never fills up, so commands are always taken.
  assign busy_o     = 1'b0;
  assign in_valid_d = start_i && !busy_o;

  // Input and result register strobes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= in_valid_q;
    end
  end

  // Input payload captured on each accepted transfer.
  always_ff @(posedge clk_i) begin
    if (in_valid_d) begin
      in_q <= cmd_i;
    end
  end

  cod_decode u_decode (
    .cmd_i (in_q),
    .res_o (out_d)
  );

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (in_valid_q) begin
      out_q <= out_d;
    end
  end

  assign done_o = out_valid_q;
  assign res_o  = out_q;

endmodule

`default_nettype wire

// ===== sv/cod_decode.sv =====
// Combinational decode of one registered opcode pair into a record.
// Depends on cod_pkg for the payload types and code constants.
`default_nettype none

module cod_decode (
  input  cod_pkg::cod_in_t  cmd_i,
  output cod_pkg::cod_out_t res_o
);
  import cod_pkg::*;

  logic [7:0] op;
  logic [7:0] nb;
  logic [3:0] row_tgt;

  assign op      = cmd_i.opcode;
  assign nb      = cmd_i.next_byte;
  assign row_tgt = {1'b0, op[5:3]};

  // Priority decode: prefix table, ALU register, ALU immediate, low block, singles.
  always_comb begin
    res_o = '{valid_res: 1'b0, kind: K_INCDUP, length: LEN_1, target: T_NONE,
              immediate: 8'd0, bit_index: 3'd0, prefixed: 1'b0};
    if (op == OP_PREFIX) begin
      res_o.valid_res = 1'b1;
      res_o.length    = LEN_2;
      res_o.target    = {1'b0, nb[2:0]};
      res_o.prefixed  = 1'b1;
      if (nb[7:6] == 2'd0) begin
        res_o.kind = K_CB_BASE + {3'd0, nb[5:3]};
      end else begin
        res_o.kind      = K_BIT + {4'd0, nb[7:6]} - 6'd1;
        res_o.bit_index = nb[5:3];
      end
    end else if (op inside {[8'h80:8'hBF]}) begin
      res_o.valid_res = 1'b1;
      res_o.kind      = K_ALU_BASE + {3'd0, op[5:3]};
      res_o.target    = {1'b0, op[2:0]};
    end else if (op[7:6] == 2'b11 && op[2:0] == COL_IMM) begin
      res_o.valid_res = 1'b1;
      res_o.kind      = K_ALU_BASE + {3'd0, op[5:3]};
      res_o.length    = LEN_2;
      res_o.target    = T_IMM;
      res_o.immediate = nb;
    end else if (op[7:6] == 2'b00 && (op[3:0] inside {LO_INC16, LO_ADDHL, LO_DEC16,
                 LO_INC_A, LO_INC_B, LO_DEC_A, LO_DEC_B})) begin
      res_o.valid_res = 1'b1;
      case (op[3:0])
        LO_INC16: begin
          res_o.kind   = K_INCDUP;
          res_o.target = pair_target(op[5:4]);
        end
        LO_ADDHL: begin
          res_o.kind   = K_ADDHL;
          res_o.target = pair_target(op[5:4]);
        end
        LO_DEC16: begin
          res_o.kind   = K_DECDUP;
          res_o.target = pair_target(op[5:4]);
        end
        LO_INC_A, LO_INC_B: begin
          res_o.kind   = K_INC;
          res_o.target = row_tgt;
        end
        default: begin
          res_o.kind   = K_DEC;
          res_o.target = row_tgt;
        end
      endcase
    end else begin
      res_o.valid_res = 1'b1;
      case (op)
        OP_RLCA:  res_o.kind = K_RLCA;
        OP_RLA:   res_o.kind = K_RLA;
        OP_SCF:   res_o.kind = K_SCF;
        OP_RRCA:  res_o.kind = K_RRCA;
        OP_RRA:   res_o.kind = K_RRA;
        OP_CPL:   res_o.kind = K_CPL;
        OP_CCF:   res_o.kind = K_CCF;
        OP_JR_NZ: begin
          res_o.kind   = K_JRNZERO;
          res_o.length = LEN_2;
        end
        OP_JR_NC: begin
          res_o.kind   = K_JRNCARRY;
          res_o.length = LEN_2;
        end
        OP_JR: begin
          res_o.kind   = K_JRALWAYS;
          res_o.length = LEN_2;
        end
        OP_JR_Z: begin
          res_o.kind   = K_JRZERO;
          res_o.length = LEN_2;
        end
        OP_JR_C: begin
          res_o.kind   = K_JRCARRY;
          res_o.length = LEN_2;
        end
        OP_JP_NZ: begin
          res_o.kind   = K_JPNZERO;
          res_o.length = LEN_3;
        end
        OP_JP_NC: begin
          res_o.kind   = K_JPNCARRY;
          res_o.length = LEN_3;
        end
        OP_JP: begin
          res_o.kind   = K_JPALWAYS;
          res_o.length = LEN_3;
        end
        OP_JP_Z: begin
          res_o.kind   = K_JPZERO;
          res_o.length = LEN_3;
        end
        OP_JP_C: begin
          res_o.kind   = K_JPCARRY;
          res_o.length = LEN_3;
        end
        OP_JP_HL: begin
          // Jump to HL is a single-byte instruction.
          res_o.kind   = K_JPALWAYS;
          res_o.target = T_HL;
        end
        default: res_o.valid_res = 1'b0;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/cod_checker.sv =====
// Port-level checker for cpu_opcode_decoder, bound to the top level below.
// Depends on cod_pkg and the macros in cpu_opcode_decoder_macros.svh.
`default_nettype none
`include "cpu_opcode_decoder_macros.svh"

module cod_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input logic              busy_o,
  input cod_pkg::cod_in_t  cmd_i,
  input logic              done_o,
  input cod_pkg::cod_out_t res_o
);
  import cod_pkg::*;

  // Every accepted transfer gives a result strobe.
  `COD_ASSERT_LAT2(a_latency, start_i && !busy_o, done_o)

  // The prefixed flag follows whether the accepted opcode was the prefix.
  `COD_ASSERT_LAT2(a_prefix_flag, start_i && !busy_o,
                   res_o.prefixed == ($past(cmd_i.opcode, 2) == OP_PREFIX))

  // A prefixed result is always valid and two bytes long.
  `COD_ASSERT_IMPL(a_prefix_len, done_o && res_o.prefixed,
                   res_o.valid_res && res_o.length == LEN_2)

  // An unlisted opcode gives the neutral record.
  `COD_ASSERT_IMPL(a_unlisted, done_o && !res_o.valid_res,
                   res_o.length == LEN_1 && res_o.target == T_NONE &&
                   res_o.kind == K_INCDUP && res_o.immediate == 8'd0)

endmodule

bind cpu_opcode_decoder cod_checker u_cod_checker (.*);

`default_nettype wire
